[design/led_blink_breathe_effect_engine_assert.svh]
// Assertion macros for the LED effect engine.
// Both forms use the clock clk and the synchronous active-low reset rst_n of
// the module that includes this header.
`ifndef LED_BLINK_BREATHE_EFFECT_ENGINE_ASSERT_SVH
`define LED_BLINK_BREATHE_EFFECT_ENGINE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define LBE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("LED effect engine: same-cycle check failed");
// Next-cycle implication.
`define LBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("LED effect engine: next-cycle check failed");
`else
`define LBE_ASSERT_NOW(lbl, ante, cons)
`define LBE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/lbbe_pkg.sv]
package lbbe_pkg;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned WaitW   = 16;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned PulseW  = 8;
  localparam int unsigned LevelW  = 5;
  localparam int unsigned ModeW   = 2;

  localparam logic [LevelW-1:0] RAMP_TOP = LevelW'(20);

  typedef enum logic [ModeW-1:0] {
    MODE_STEADY  = 2'd0,
    MODE_BREATHE = 2'd1,
    MODE_BLINK   = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_EFFECT_MODE  = 3'd0,
    REG_ON_DUTY      = 3'd1,
    REG_PULSES       = 3'd2,
    REG_LIT_MS       = 3'd3,
    REG_DARK_MS      = 3'd4,
    REG_PAUSE_MS     = 3'd5,
    REG_STEP_PERIOD  = 3'd6,
    REG_NONE         = 3'd7
  } reg_idx_t;

  // Zero intervals count as one tick.
  function automatic logic [WaitW-1:0] at_least_one(input logic [WaitW-1:0] v);
    at_least_one = (v == '0) ? WaitW'(1) : v;
  endfunction

  // floor(level * 255 / 20) == floor(level * 51 / 4)
  function automatic logic [DutyW-1:0] ramp_duty(input logic [LevelW-1:0] lvl);
    logic [LevelW+5:0] prod;
    prod = {6'd0, lvl} * (LevelW + 6)'(51);
    ramp_duty = prod[DutyW+1:2];
  endfunction

endpackage

[design/led_blink_breathe_effect_engine.sv]
// LED blink / breathe effect engine: one millisecond tick request in, one duty result out.
// A result is registered from its accepted request, into the output register or, while that is held, the skid entry.
// Throughput: one request per cycle while the skid entry is empty; a two-entry output buffer keeps input open
//   while one result waits on a stalled output.
// Reset (rst_n low, synchronous): registers to their defaults, effect state cleared,
//   ramp rising, output buffer empty.
`include "led_blink_breathe_effect_engine_assert.svh"

module led_blink_breathe_effect_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_restart,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lbbe_pkg::DutyW-1:0] out_pwm_duty,
  output logic                       out_group_end,
  // configuration (APB style)
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbbe_pkg::AddrW-1:0] paddr,
  input  logic [lbbe_pkg::DataW-1:0] pwdata,
  output logic [lbbe_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import lbbe_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ModeW-1:0]  mode_r;
  logic [DutyW-1:0]  on_duty_r;
  logic [PulseW-1:0] pulses_per_group_r;
  logic [WaitW-1:0]  lit_ms_r;
  logic [WaitW-1:0]  dark_ms_r;
  logic [WaitW-1:0]  pause_ms_r;
  logic [WaitW-1:0]  step_period_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r             <= MODE_STEADY;
      on_duty_r          <= '0;
      pulses_per_group_r <= PulseW'(1);
      lit_ms_r           <= WaitW'(100);
      dark_ms_r          <= WaitW'(100);
      pause_ms_r         <= '0;
      step_period_r      <= WaitW'(50);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_EFFECT_MODE: mode_r             <= pwdata[ModeW-1:0];
        REG_ON_DUTY:     on_duty_r          <= pwdata[DutyW-1:0];
        REG_PULSES:      pulses_per_group_r <= pwdata[PulseW-1:0];
        REG_LIT_MS:      lit_ms_r           <= pwdata[WaitW-1:0];
        REG_DARK_MS:     dark_ms_r          <= pwdata[WaitW-1:0];
        REG_PAUSE_MS:    pause_ms_r         <= pwdata[WaitW-1:0];
        REG_STEP_PERIOD: step_period_r      <= pwdata[WaitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_EFFECT_MODE: prdata = DataW'(mode_r);
      REG_ON_DUTY:     prdata = DataW'(on_duty_r);
      REG_PULSES:      prdata = DataW'(pulses_per_group_r);
      REG_LIT_MS:      prdata = DataW'(lit_ms_r);
      REG_DARK_MS:     prdata = DataW'(dark_ms_r);
      REG_PAUSE_MS:    prdata = DataW'(pause_ms_r);
      REG_STEP_PERIOD: prdata = DataW'(step_period_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effect state, updated once per accepted request
  // ---------------------------------------------------------------------------
  logic [WaitW-1:0]  wait_left_r,   wait_left_nxt;
  logic              lit_now_r,     lit_now_nxt;
  logic [PulseW-1:0] pulses_done_r, pulses_done_nxt;
  logic [LevelW-1:0] ramp_level_r,  ramp_level_nxt;
  logic              ramp_rising_r, ramp_rising_nxt;
  logic [DutyW-1:0]  held_duty_r,   held_duty_nxt;
  logic              group_end_nxt;

  logic              in_acc;
  logic              expired;
  logic [PulseW-1:0] pulses_inc;
  logic [PulseW-1:0] group_limit;
  logic [WaitW-1:0]  pause_pick;
  logic [LevelW-1:0] lvl_step;

  assign in_acc      = in_valid & ~in_stall;
  // wait_left of 0 or 1 means the pending event fires on this tick
  assign expired     = (wait_left_r <= WaitW'(1));
  assign pulses_inc  = pulses_done_r + PulseW'(1);
  assign group_limit = (pulses_per_group_r == '0) ? PulseW'(1) : pulses_per_group_r;
  assign pause_pick  = (pause_ms_r != '0) ? pause_ms_r : dark_ms_r;

  always_comb begin
    if (ramp_rising_r) begin
      lvl_step = (ramp_level_r < RAMP_TOP) ? ramp_level_r + LevelW'(1) : ramp_level_r;
    end else begin
      lvl_step = (ramp_level_r != '0) ? ramp_level_r - LevelW'(1) : ramp_level_r;
    end
  end

  always_comb begin
    wait_left_nxt   = wait_left_r;
    lit_now_nxt     = lit_now_r;
    pulses_done_nxt = pulses_done_r;
    ramp_level_nxt  = ramp_level_r;
    ramp_rising_nxt = ramp_rising_r;
    held_duty_nxt   = held_duty_r;
    group_end_nxt   = 1'b0;

    case (mode_t'(mode_r))
      MODE_BREATHE: begin
        if (in_restart) begin
          ramp_level_nxt  = '0;
          ramp_rising_nxt = 1'b1;
          held_duty_nxt   = '0;
          wait_left_nxt   = at_least_one(step_period_r);
        end else if (expired) begin
          // duty uses the level before the step; direction flips at either end
          held_duty_nxt   = ramp_duty(ramp_level_r);
          ramp_level_nxt  = lvl_step;
          ramp_rising_nxt = ((lvl_step >= RAMP_TOP) || (lvl_step == '0)) ?
                            ~ramp_rising_r : ramp_rising_r;
          wait_left_nxt   = at_least_one(step_period_r);
        end else begin
          wait_left_nxt   = wait_left_r - WaitW'(1);
        end
      end
      MODE_BLINK: begin
        if (in_restart) begin
          lit_now_nxt     = 1'b0;
          pulses_done_nxt = '0;
          held_duty_nxt   = '0;
          wait_left_nxt   = at_least_one(dark_ms_r);
        end else if (expired) begin
          if (lit_now_r) begin
            held_duty_nxt = '0;
            lit_now_nxt   = 1'b0;
            if (pulses_inc >= group_limit) begin
              pulses_done_nxt = '0;
              group_end_nxt   = 1'b1;
              wait_left_nxt   = at_least_one(pause_pick);
            end else begin
              pulses_done_nxt = pulses_inc;
              wait_left_nxt   = at_least_one(dark_ms_r);
            end
          end else begin
            held_duty_nxt = on_duty_r;
            lit_now_nxt   = 1'b1;
            wait_left_nxt = at_least_one(lit_ms_r);
          end
        end else begin
          wait_left_nxt = wait_left_r - WaitW'(1);
        end
      end
      default: begin
        // steady, and the unused fourth code behaves the same
        held_duty_nxt = on_duty_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_left_r   <= '0;
      lit_now_r     <= 1'b0;
      pulses_done_r <= '0;
      ramp_level_r  <= '0;
      ramp_rising_r <= 1'b1;
      held_duty_r   <= '0;
    end else if (in_acc) begin
      wait_left_r   <= wait_left_nxt;
      lit_now_r     <= lit_now_nxt;
      pulses_done_r <= pulses_done_nxt;
      ramp_level_r  <= ramp_level_nxt;
      ramp_rising_r <= ramp_rising_nxt;
      held_duty_r   <= held_duty_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer: output register plus one skid entry
  // ---------------------------------------------------------------------------
  logic              out_valid_r;
  logic [DutyW-1:0]  out_duty_r;
  logic              out_end_r;
  logic              skid_valid_r;
  logic [DutyW-1:0]  skid_duty_r;
  logic              skid_end_r;
  logic              out_take;

  assign out_take      = out_valid_r & ~out_stall;
  // input closes only when both entries are full
  assign in_stall      = skid_valid_r;
  assign out_valid     = out_valid_r;
  assign out_pwm_duty  = out_duty_r;
  assign out_group_end = out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_take) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (!out_valid_r) begin
        out_valid_r <= in_acc;
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && skid_valid_r) begin
      out_duty_r <= skid_duty_r;
      out_end_r  <= skid_end_r;
    end else if (in_acc && (out_take || !out_valid_r)) begin
      out_duty_r <= held_duty_nxt;
      out_end_r  <= group_end_nxt;
    end
    if (in_acc && out_valid_r && !out_take) begin
      skid_duty_r <= held_duty_nxt;
      skid_end_r  <= group_end_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `LBE_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `LBE_ASSERT_NOW(a_ramp_in_range, 1'b1, ramp_level_r <= RAMP_TOP)
  `LBE_ASSERT_NEXT(a_stalled_goes_to_skid, out_valid_r && out_stall && in_acc, skid_valid_r)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import lbbe_pkg::*;

  localparam int unsigned RAMP_PEAK     = 20;
  localparam int unsigned RANDOM_TICKS  = 1050;
  localparam int unsigned STUCK_LIMIT   = 4000;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             group_end;
  } duty_t;

  logic                 clk;
  logic                 rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_restart = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DutyW-1:0]     out_pwm_duty;
  logic                 out_group_end;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrW-1:0]     paddr = '0;
  logic [DataW-1:0]     pwdata = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  led_blink_breathe_effect_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pwm_duty  (out_pwm_duty),
    .out_group_end (out_group_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 125 MHz
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Local copy of the engine's settings, mirrored on every register write
  // ---------------------------------------------------------------------------
  mode_t            sel_mode    = MODE_STEADY;
  logic [DutyW-1:0] lit_duty    = '0;
  logic [7:0]       group_len   = 8'd1;
  logic [WaitW-1:0] lit_ticks   = 16'd100;
  logic [WaitW-1:0] dark_ticks  = 16'd100;
  logic [WaitW-1:0] pause_ticks = 16'd0;
  logic [WaitW-1:0] step_ticks  = 16'd50;

  // Effect state as it stands after the last accepted request
  logic [WaitW-1:0] ticks_to_event  = '0;
  logic             led_lit         = 1'b0;
  logic [7:0]       pulses_in_group = '0;
  logic [4:0]       ramp_step       = '0;
  logic             ramp_up         = 1'b1;
  logic [DutyW-1:0] duty_now        = '0;

  duty_t duty_due[$];   // results still owed by the engine, oldest first

  int unsigned ticks_sent;
  int unsigned restarts_sent;
  int unsigned duties_seen;
  int unsigned group_ends_seen;
  int unsigned reg_writes;
  int unsigned mismatches;

  bit          valid_up;   // what was last scheduled onto in_valid
  bit          no_gaps;    // both sides run flat out while set

  function automatic logic [WaitW-1:0] nonzero_ticks(input logic [WaitW-1:0] v);
    return (v == '0) ? WaitW'(1) : v;
  endfunction

  // One tick of the shared wait counter; true when the pending event is due.
  // The counter is not touched on a firing tick: the event reloads it.
  function automatic bit tick_fires();
    if (ticks_to_event <= 16'd1) return 1'b1;
    ticks_to_event = ticks_to_event - 16'd1;
    return 1'b0;
  endfunction

  function automatic duty_t advance_led_effect(input logic restart);
    duty_t r;
    r.group_end = 1'b0;
    case (sel_mode)
      MODE_BREATHE: begin
        if (restart) begin
          ramp_step      = '0;
          ramp_up        = 1'b1;
          duty_now       = '0;
          ticks_to_event = nonzero_ticks(step_ticks);
        end else if (tick_fires()) begin
          // duty follows the level before the step; exact floor of level*255/20
          duty_now = DutyW'((32'(ramp_step) * 255) / RAMP_PEAK);
          if (ramp_up && ramp_step < RAMP_PEAK) ramp_step = ramp_step + 5'd1;
          else if (!ramp_up && ramp_step != 0) ramp_step = ramp_step - 5'd1;
          // turn at either end so each extreme lasts one step period
          if (ramp_step >= RAMP_PEAK || ramp_step == 0) ramp_up = !ramp_up;
          ticks_to_event = nonzero_ticks(step_ticks);
        end
      end
      MODE_BLINK: begin
        if (restart) begin
          led_lit         = 1'b0;
          pulses_in_group = '0;
          duty_now        = '0;
          ticks_to_event  = nonzero_ticks(dark_ticks);
        end else if (tick_fires()) begin
          if (led_lit) begin
            duty_now        = '0;
            led_lit         = 1'b0;
            pulses_in_group = pulses_in_group + 8'd1;
            // a limit lowered mid-group still ends it at this pulse
            if (WaitW'(pulses_in_group) >= nonzero_ticks(WaitW'(group_len))) begin
              pulses_in_group = '0;
              r.group_end     = 1'b1;
              ticks_to_event  = nonzero_ticks((pause_ticks != '0) ? pause_ticks
                                                                   : dark_ticks);
            end else begin
              ticks_to_event = nonzero_ticks(dark_ticks);
            end
          end else begin
            duty_now       = lit_duty;
            led_lit        = 1'b1;
            ticks_to_event = nonzero_ticks(lit_ticks);
          end
        end
      end
      // steady, and the spare code which acts as steady
      default: duty_now = lit_duty;
    endcase
    r.duty = duty_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request monitor and result checker. Predicting first keeps the order right
  // even if a result ever came back in the cycle of its request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    duty_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        duty_due.push_back(advance_led_effect(in_restart));
        ticks_sent++;
        if (in_restart) restarts_sent++;
      end
      if (out_valid && !out_stall) begin
        duties_seen++;
        if (out_group_end) group_ends_seen++;
        if (duty_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: duty %0d end %0b", out_pwm_duty, out_group_end);
        end else begin
          want = duty_due.pop_front();
          if (out_pwm_duty !== want.duty || out_group_end !== want.group_end) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result %0d: expected duty %0d end %0b, got duty %0d end %0b",
                       duties_seen, want.duty, want.group_end,
                       out_pwm_duty, out_group_end);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side back-pressure: a fresh random stall, possibly none, ahead of each result
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any request, result or register write
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pready))
        stuck = 0;
      else
        stuck++;
    end
    $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
    $display("led_blink_breathe_effect_engine: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------

  // One tick request; in_valid stays up between back-to-back requests.
  task automatic send_tick(input logic restart);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      if (valid_up) begin
        in_valid <= 1'b0;
        valid_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    if (!valid_up) begin
      in_valid <= 1'b1;
      valid_up = 1'b1;
    end
    in_restart <= restart;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Drop the request line and wait for every owed result. The first edge lets
  // the monitor log the last accepted request before the queue is looked at.
  task automatic settle();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk);
    while (duty_due.size() != 0) @(posedge clk);
  endtask

  // Setup then access phase; the write lands at the access edge with pready up.
  task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
    case (idx)
      REG_EFFECT_MODE: sel_mode    = mode_t'(value[ModeW-1:0]);
      REG_ON_DUTY:     lit_duty    = value[DutyW-1:0];
      REG_PULSES:      group_len   = value[7:0];
      REG_LIT_MS:      lit_ticks   = value[WaitW-1:0];
      REG_DARK_MS:     dark_ticks  = value[WaitW-1:0];
      REG_PAUSE_MS:    pause_ticks = value[WaitW-1:0];
      REG_STEP_PERIOD: step_ticks  = value[WaitW-1:0];
      default: ;
    endcase
  endtask

  // Mostly short intervals so events fire often; now and then long or full scale.
  function automatic logic [WaitW-1:0] pick_interval();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 12) return WaitW'($urandom_range(0, 6));
    if (r < 14) return WaitW'($urandom_range(7, 40));
    if (r == 14) return '1;
    return WaitW'($urandom);
  endfunction

  function automatic logic [7:0] pick_group_len();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 12) return 8'($urandom_range(0, 4));
    if (r < 15) return 8'($urandom_range(5, 16));
    return 8'hFF;
  endfunction

  function automatic mode_t pick_mode();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return MODE_STEADY;
    if (r == 1) return MODE_SPARE;
    if (r < 6) return MODE_BREATHE;
    return MODE_BLINK;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight after reset the wait counter is zero, so a plain tick fires at once.
  task automatic test_first_tick_fires();
    settle();
    write_reg(REG_EFFECT_MODE, DataW'(MODE_BREATHE));
    send_tick(1'b0);
  endtask

  // Steady level at both extremes; the spare mode code must act as steady.
  task automatic test_steady_levels();
    settle();
    write_reg(REG_ON_DUTY, 32'hFF);
    write_reg(REG_EFFECT_MODE, DataW'(MODE_STEADY));
    send_tick(1'b0);
    send_tick(1'b1);
    settle();
    write_reg(REG_ON_DUTY, 32'h0);
    write_reg(REG_EFFECT_MODE, DataW'(MODE_SPARE));
    send_tick(1'b0);
  endtask

  // Zero step period counts as one tick: ramp moves every request.
  task automatic test_breathe_ramp();
    settle();
    write_reg(REG_STEP_PERIOD, 32'h0);
    write_reg(REG_EFFECT_MODE, DataW'(MODE_BREATHE));
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  // Two one-tick pulses then a two-tick pause, group end flagged on the second.
  task automatic test_blink_groups();
    settle();
    write_reg(REG_EFFECT_MODE, DataW'(MODE_BLINK));
    write_reg(REG_ON_DUTY, 32'hC3);
    write_reg(REG_LIT_MS, 32'h0);
    write_reg(REG_DARK_MS, 32'h0);
    write_reg(REG_PAUSE_MS, 32'h2);
    write_reg(REG_PULSES, 32'h2);
    send_tick(1'b1);
    repeat (6) send_tick(1'b0);
  endtask

  // Limit cut below the pulses already done: the next pulse ends the group.
  task automatic test_group_limit_lowered();
    settle();
    write_reg(REG_PULSES, 32'h3);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    settle();
    write_reg(REG_PULSES, 32'h0);
    repeat (2) send_tick(1'b0);
  endtask

  // Every duty, pulse and interval register at full scale, then a mode switch with no restart.
  task automatic test_register_extremes();
    settle();
    write_reg(REG_ON_DUTY, 32'hFF);
    write_reg(REG_PULSES, 32'hFF);
    write_reg(REG_LIT_MS, 32'hFFFF);
    write_reg(REG_DARK_MS, 32'hFFFF);
    write_reg(REG_PAUSE_MS, 32'hFFFF);
    write_reg(REG_STEP_PERIOD, 32'hFFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();
    write_reg(REG_EFFECT_MODE, DataW'(MODE_BREATHE));
    send_tick(1'b0);
  endtask

  // Phases of random settings, each followed by a run of ticks with the odd
  // restart. Some phases skip the restart so a new mode picks up the old state.
  task automatic test_random_traffic();
    int unsigned done;
    int unsigned run;
    done = 0;
    while (done < RANDOM_TICKS) begin
      settle();
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) write_reg(REG_EFFECT_MODE, DataW'(pick_mode()));
      if ($urandom_range(0, 1) != 0) write_reg(REG_ON_DUTY, DataW'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) != 0) write_reg(REG_PULSES, DataW'(pick_group_len()));
      if ($urandom_range(0, 1) != 0) write_reg(REG_LIT_MS, DataW'(pick_interval()));
      if ($urandom_range(0, 1) != 0) write_reg(REG_DARK_MS, DataW'(pick_interval()));
      if ($urandom_range(0, 1) != 0) write_reg(REG_PAUSE_MS, DataW'(pick_interval()));
      if ($urandom_range(0, 1) != 0) write_reg(REG_STEP_PERIOD, DataW'(pick_interval()));
      run = $urandom_range(15, 60);
      for (int unsigned i = 0; i < run; i++) begin
        if (i == 0) send_tick(1'($urandom_range(0, 1)));
        else send_tick($urandom_range(0, 23) == 0);
        done++;
      end
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_tick_fires();
    test_steady_levels();
    test_breathe_ramp();
    test_blink_groups();
    test_group_limit_lowered();
    test_register_extremes();
    test_random_traffic();

    settle();
    // let anything stray show up before the owed queue is counted
    repeat (8) @(posedge clk);
    mismatches += duty_due.size();

    $display("run: %0d tick requests (%0d restarts), %0d results checked",
             ticks_sent, restarts_sent, duties_seen);
    $display("run: %0d group ends seen, %0d register writes",
             group_ends_seen, reg_writes);
    if (mismatches == 0) begin
      $display("led_blink_breathe_effect_engine: match");
    end else begin
      $display("%0d failures", mismatches);
      $display("led_blink_breathe_effect_engine: mismatch");
    end
    $finish;
  end

endmodule
